>>> sv/rad_pkg.sv
`default_nettype none
package rad_pkg;

  // Result kinds.
  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_DATA   = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  // Sub-header geometry.
  localparam logic [3:0] HDR_LEN        = 4'd11;
  localparam logic [3:0] HDR_SHIFT_LEN  = 4'd8;
  localparam int         SID_WIDTH      = 24;
  localparam logic [31:0] TS_MASK       = 32'h7FFF_FFFF;
  localparam logic [23:0] BACKPTR_LEN   = 24'd4;

  // Forwarded sub-message types.
  localparam logic [7:0] TYPE_AUDIO = 8'd8;
  localparam logic [7:0] TYPE_VIDEO = 8'd9;

  typedef struct packed {
    logic [7:0]  payload_byte;
    logic        aggregate_start;
    logic [23:0] aggregate_length;
    logic [31:0] parent_timestamp;
  } in_item_t;

  typedef struct packed {
    logic [1:0]           kind;
    logic [7:0]           sub_type;
    logic [23:0]          payload_size;
    logic [31:0]          rebased_timestamp;
    logic [30:0]          raw_timestamp;
    logic [SID_WIDTH-1:0] sub_stream_id;
    logic [7:0]           data_out;
    logic                 last_of_message;
  } res_t;

  // Handshake between the parser and the output register.
  typedef struct packed {
    logic valid;
    res_t res;
  } res_stat_t;

endpackage
`default_nettype wire

>>> sv/rad_ifs.sv
`default_nettype none
interface rad_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  payload_byte;
  logic        aggregate_start;
  logic [23:0] aggregate_length;
  logic [31:0] parent_timestamp;

  modport source (output valid, payload_byte, aggregate_start, aggregate_length,
                  parent_timestamp, input ready);
  modport sink (input valid, payload_byte, aggregate_start, aggregate_length,
                parent_timestamp, output ready);
endinterface

interface rad_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  sub_type;
  logic [23:0] payload_size;
  logic [31:0] rebased_timestamp;
  logic [30:0] raw_timestamp;
  logic [23:0] sub_stream_id;
  logic [7:0]  data_out;
  logic        last_of_message;

  modport source (output valid, kind, sub_type, payload_size, rebased_timestamp,
                  raw_timestamp, sub_stream_id, data_out, last_of_message,
                  input ready);
  modport sink (input valid, kind, sub_type, payload_size, rebased_timestamp,
                raw_timestamp, sub_stream_id, data_out, last_of_message,
                output ready);
endinterface
`default_nettype wire

>>> sv/rad_in_reg.sv
`default_nettype none
module rad_in_reg (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire rad_pkg::in_item_t in_item,
  input  wire logic              advance,
  output logic                   item_valid,
  output rad_pkg::in_item_t      item
);

  logic              valid_r, valid_nxt;
  rad_pkg::in_item_t item_r;

  assign in_ready   = !valid_r || advance;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_ready) begin
      valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= in_item;
    end
  end

endmodule
`default_nettype wire

>>> sv/rad_parser.sv
`default_nettype none
module rad_parser (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              advance,
  input  wire rad_pkg::in_item_t item,
  output rad_pkg::res_stat_t     stat
);

  localparam logic [1:0] PH_HEADER  = 2'd0;
  localparam logic [1:0] PH_DATA    = 2'd1;
  localparam logic [1:0] PH_BACKPTR = 2'd2;

  logic [1:0]  phase_r, phase_nxt;
  logic [3:0]  field_count_r, field_count_nxt;
  logic [23:0] bla_r, bla_nxt;
  logic [23:0] blm_r, blm_nxt;
  logic [63:0] hdr_shift_r, hdr_shift_nxt;
  logic [rad_pkg::SID_WIDTH-1:0] sid_shift_r, sid_shift_nxt;
  logic [30:0] base_time_r, base_time_nxt;
  logic        have_base_r, have_base_nxt;
  logic [31:0] parent_time_r, parent_time_nxt;
  logic        fwd_r, fwd_nxt;

  logic [7:0]  hdr_type;
  logic [23:0] hdr_size;
  logic [30:0] hdr_ts;

  always_comb begin
    phase_nxt       = phase_r;
    field_count_nxt = field_count_r;
    bla_nxt         = bla_r;
    blm_nxt         = blm_r;
    hdr_shift_nxt   = hdr_shift_r;
    sid_shift_nxt   = sid_shift_r;
    base_time_nxt   = base_time_r;
    have_base_nxt   = have_base_r;
    parent_time_nxt = parent_time_r;
    fwd_nxt         = fwd_r;
    stat            = '0;

    hdr_type = hdr_shift_nxt[63:56];
    hdr_size = hdr_shift_nxt[55:32];
    hdr_ts   = 31'({hdr_shift_nxt[7:0], hdr_shift_nxt[31:8]} & rad_pkg::TS_MASK);

    if (advance) begin
      // A start flag resets the parse even in the middle of an aggregate.
      if (item.aggregate_start) begin
        bla_nxt         = item.aggregate_length;
        parent_time_nxt = item.parent_timestamp;
        have_base_nxt   = 1'b0;
        phase_nxt       = PH_HEADER;
        field_count_nxt = '0;
        blm_nxt         = '0;
        fwd_nxt         = 1'b0;
      end
      if (bla_nxt != '0) begin
        bla_nxt = bla_nxt - 24'd1;
        case (phase_nxt)
          PH_HEADER: begin
            if (field_count_nxt < rad_pkg::HDR_SHIFT_LEN) begin
              hdr_shift_nxt = {hdr_shift_nxt[55:0], item.payload_byte};
            end else begin
              sid_shift_nxt = {sid_shift_nxt[rad_pkg::SID_WIDTH-9:0], item.payload_byte};
            end
            field_count_nxt = field_count_nxt + 4'd1;
            hdr_type = hdr_shift_nxt[63:56];
            hdr_size = hdr_shift_nxt[55:32];
            hdr_ts   = 31'({hdr_shift_nxt[7:0], hdr_shift_nxt[31:8]} & rad_pkg::TS_MASK);
            if (field_count_nxt < rad_pkg::HDR_LEN) begin
              if (bla_nxt == '0) begin
                stat.valid      = 1'b1;
                stat.res.kind   = rad_pkg::KIND_ERROR;
                phase_nxt       = PH_HEADER;
                field_count_nxt = '0;
                blm_nxt         = '0;
                fwd_nxt         = 1'b0;
              end
            end else begin
              field_count_nxt = '0;
              // The first sub-message of an aggregate sets the time base.
              if (!have_base_nxt) begin
                base_time_nxt = hdr_ts;
                have_base_nxt = 1'b1;
              end
              if ({1'b0, bla_nxt} < ({1'b0, hdr_size} + {1'b0, rad_pkg::BACKPTR_LEN})) begin
                stat.valid      = 1'b1;
                stat.res.kind   = rad_pkg::KIND_ERROR;
                bla_nxt         = '0;
                phase_nxt       = PH_HEADER;
                field_count_nxt = '0;
                blm_nxt         = '0;
                fwd_nxt         = 1'b0;
              end else begin
                fwd_nxt = (hdr_type == rad_pkg::TYPE_AUDIO) ||
                          (hdr_type == rad_pkg::TYPE_VIDEO);
                if (hdr_size != '0) begin
                  phase_nxt = PH_DATA;
                  blm_nxt   = hdr_size;
                end else begin
                  phase_nxt = PH_BACKPTR;
                  blm_nxt   = rad_pkg::BACKPTR_LEN;
                end
                if (fwd_nxt) begin
                  stat.valid                 = 1'b1;
                  stat.res.kind              = rad_pkg::KIND_HEADER;
                  stat.res.sub_type          = hdr_type;
                  stat.res.payload_size      = hdr_size;
                  stat.res.rebased_timestamp = parent_time_nxt +
                                               ({1'b0, hdr_ts} - {1'b0, base_time_nxt});
                  stat.res.raw_timestamp     = hdr_ts;
                  stat.res.sub_stream_id     = sid_shift_nxt;
                end
              end
            end
          end
          PH_DATA: begin
            blm_nxt = blm_nxt - 24'd1;
            if (fwd_nxt) begin
              stat.valid               = 1'b1;
              stat.res.kind            = rad_pkg::KIND_DATA;
              stat.res.data_out        = item.payload_byte;
              stat.res.last_of_message = (blm_nxt == '0);
            end
            if (blm_nxt == '0) begin
              phase_nxt = PH_BACKPTR;
              blm_nxt   = rad_pkg::BACKPTR_LEN;
            end
          end
          default: begin
            // Back-pointer bytes are counted off and dropped.
            if (blm_nxt != '0) begin
              blm_nxt = blm_nxt - 24'd1;
            end
            if (blm_nxt == '0) begin
              phase_nxt       = PH_HEADER;
              field_count_nxt = '0;
              fwd_nxt         = 1'b0;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_HEADER;
      field_count_r <= '0;
      bla_r         <= '0;
      blm_r         <= '0;
      have_base_r   <= 1'b0;
      fwd_r         <= 1'b0;
    end else begin
      phase_r       <= phase_nxt;
      field_count_r <= field_count_nxt;
      bla_r         <= bla_nxt;
      blm_r         <= blm_nxt;
      have_base_r   <= have_base_nxt;
      fwd_r         <= fwd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hdr_shift_r   <= hdr_shift_nxt;
    sid_shift_r   <= sid_shift_nxt;
    base_time_r   <= base_time_nxt;
    parent_time_r <= parent_time_nxt;
  end

`ifndef SYNTHESIS
  a_fc_range: assert property (@(posedge clk) disable iff (!rst_n)
    field_count_r < rad_pkg::HDR_LEN)
    else $error("field count out of range");

  a_fc_header: assert property (@(posedge clk) disable iff (!rst_n)
    (field_count_r != '0) |-> (phase_r == PH_HEADER))
    else $error("field count nonzero outside header phase");

  a_data_left: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DATA) |-> (blm_r != '0))
    else $error("data phase with no bytes left");

  a_bp_left: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_BACKPTR) |-> ((blm_r != '0) && (blm_r <= rad_pkg::BACKPTR_LEN)))
    else $error("back-pointer count out of range");

  a_err_flush: assert property (@(posedge clk) disable iff (!rst_n)
    (stat.valid && (stat.res.kind == rad_pkg::KIND_ERROR)) |=> (bla_r == '0))
    else $error("aggregate not discarded after error");
`endif

endmodule
`default_nettype wire

>>> sv/rad_out_reg.sv
`default_nettype none
module rad_out_reg (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               advance,
  input  wire rad_pkg::res_stat_t stat,
  output logic                    can_take,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output rad_pkg::res_t           out_res
);

  logic          valid_r, valid_nxt;
  rad_pkg::res_t res_r;

  assign can_take  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_comb begin
    valid_nxt = valid_r;
    if (can_take) begin
      valid_nxt = advance && stat.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && stat.valid) begin
      res_r <= stat.res;
    end
  end

endmodule
`default_nettype wire

>>> sv/rtmp_aggregate_deframer.sv
`default_nettype none
// Aggregate message deframer: takes the aggregate payload one byte per item
// and returns the headers and data bytes of audio and video sub-messages and
// truncation errors, at most one result per byte. A byte waits in the input
// register while the parser works on it combinationally, and its result is
// registered in the output register when the byte moves on; while the output
// is not stalled the sustained rate is one byte per cycle. The parse state
// (counters and header shift registers) is updated once per byte. A byte moves
// on only when the output register can take a result, so output stalls hold
// the parser, and in_ready follows out_ready combinationally through the
// one-deep input stage.
module rtmp_aggregate_deframer (
  input wire logic clk,
  input wire logic rst_n,
  rad_in_if.sink   in_ch,
  rad_out_if.source out_ch
);

  rad_pkg::in_item_t  in_item;
  rad_pkg::in_item_t  item;
  rad_pkg::res_stat_t stat;
  rad_pkg::res_t      out_res;
  logic               item_valid;
  logic               can_take;
  logic               advance;

  assign in_item.payload_byte     = in_ch.payload_byte;
  assign in_item.aggregate_start  = in_ch.aggregate_start;
  assign in_item.aggregate_length = in_ch.aggregate_length;
  assign in_item.parent_timestamp = in_ch.parent_timestamp;

  assign advance = item_valid && can_take;

  rad_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_item    (in_item),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  rad_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .item    (item),
    .stat    (stat)
  );

  rad_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (advance),
    .stat      (stat),
    .can_take  (can_take),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_res   (out_res)
  );

  assign out_ch.kind              = out_res.kind;
  assign out_ch.sub_type          = out_res.sub_type;
  assign out_ch.payload_size      = out_res.payload_size;
  assign out_ch.rebased_timestamp = out_res.rebased_timestamp;
  assign out_ch.raw_timestamp     = out_res.raw_timestamp;
  assign out_ch.sub_stream_id     = out_res.sub_stream_id;
  assign out_ch.data_out          = out_res.data_out;
  assign out_ch.last_of_message   = out_res.last_of_message;

endmodule
`default_nettype wire

>>> tb/rad_checker.sv
`timescale 1ns / 100ps
module rad_result_checker
  import rad_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  rad_in_if    in_mon,
  rad_out_if   out_mon,
  output int   fail_count,
  output int   pending
);

  typedef enum logic [1:0] {PH_HEADER, PH_DATA, PH_BACKPTR} parse_phase_e;

  // Parser state as the block should hold it.
  parse_phase_e phase;
  logic [3:0]   hdr_count;
  logic [23:0]  agg_left;
  logic [23:0]  msg_left;
  logic [63:0]  hdr_shift;
  logic [23:0]  sid_shift;
  logic [30:0]  base_ts;
  logic         base_valid;
  logic [31:0]  parent_ts;
  logic         forward;

  res_t     predicted_results[$];
  in_item_t taken;
  res_t     got;
  res_t     want;
  res_t     made;
  logic     made_valid;

  function automatic string fmt_res(res_t r);
    return $sformatf("kind %0d type %0d size %0d ts %h raw %h sid %h data %h last %b",
                     r.kind, r.sub_type, r.payload_size, r.rebased_timestamp,
                     r.raw_timestamp, r.sub_stream_id, r.data_out, r.last_of_message);
  endfunction

  task automatic drop_aggregate();
    agg_left  = '0;
    phase     = PH_HEADER;
    hdr_count = '0;
    msg_left  = '0;
    forward   = 1'b0;
  endtask

  task automatic parse_aggregate_byte(input in_item_t it, output logic emit, output res_t r);
    logic [7:0]  b;
    logic [7:0]  mtype;
    logic [23:0] msize;
    logic [30:0] ts;
    logic        last;
    b    = it.payload_byte;
    emit = 1'b0;
    r    = '0;
    if (it.aggregate_start) begin
      agg_left   = it.aggregate_length;
      parent_ts  = it.parent_timestamp;
      base_valid = 1'b0;
      phase      = PH_HEADER;
      hdr_count  = '0;
      msg_left   = '0;
      forward    = 1'b0;
    end
    if (agg_left != '0) begin
      agg_left = agg_left - 24'd1;
      case (phase)
        PH_HEADER: begin
          if (hdr_count < HDR_SHIFT_LEN) hdr_shift = {hdr_shift[55:0], b};
          else sid_shift = {sid_shift[15:0], b};
          hdr_count = hdr_count + 4'd1;
          if (hdr_count < HDR_LEN) begin
            // The aggregate ran out in the middle of a sub-header.
            if (agg_left == '0) begin
              drop_aggregate();
              r.kind = KIND_ERROR;
              emit   = 1'b1;
            end
          end else begin
            hdr_count = '0;
            mtype = hdr_shift[63:56];
            msize = hdr_shift[55:32];
            // Timestamp extension byte supplies bits 30..24; bit 31 is masked off.
            ts = {hdr_shift[6:0], hdr_shift[31:8]};
            if (!base_valid) begin
              base_ts    = ts;
              base_valid = 1'b1;
            end
            if ({8'd0, agg_left} < {8'd0, msize} + {8'd0, BACKPTR_LEN}) begin
              drop_aggregate();
              r.kind = KIND_ERROR;
              emit   = 1'b1;
            end else begin
              forward = (mtype == TYPE_AUDIO) || (mtype == TYPE_VIDEO);
              if (msize != '0) begin
                phase    = PH_DATA;
                msg_left = msize;
              end else begin
                phase    = PH_BACKPTR;
                msg_left = BACKPTR_LEN;
              end
              if (forward) begin
                r.kind              = KIND_HEADER;
                r.sub_type          = mtype;
                r.payload_size      = msize;
                r.rebased_timestamp = parent_ts + ({1'b0, ts} - {1'b0, base_ts});
                r.raw_timestamp     = ts;
                r.sub_stream_id     = sid_shift;
                emit                = 1'b1;
              end
            end
          end
        end
        PH_DATA: begin
          msg_left = msg_left - 24'd1;
          last     = (msg_left == '0);
          if (last) begin
            phase    = PH_BACKPTR;
            msg_left = BACKPTR_LEN;
          end
          if (forward) begin
            r.kind            = KIND_DATA;
            r.data_out        = b;
            r.last_of_message = last;
            emit              = 1'b1;
          end
        end
        default: begin
          if (msg_left != '0) msg_left = msg_left - 24'd1;
          if (msg_left == '0) begin
            phase     = PH_HEADER;
            hdr_count = '0;
            forward   = 1'b0;
          end
        end
      endcase
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      phase      = PH_HEADER;
      hdr_count  = '0;
      agg_left   = '0;
      msg_left   = '0;
      hdr_shift  = '0;
      sid_shift  = '0;
      base_ts    = '0;
      base_valid = 1'b0;
      parent_ts  = '0;
      forward    = 1'b0;
      fail_count = 0;
      predicted_results.delete();
    end else begin
      if (in_mon.valid && in_mon.ready) begin
        taken = {in_mon.payload_byte, in_mon.aggregate_start, in_mon.aggregate_length,
                 in_mon.parent_timestamp};
        parse_aggregate_byte(taken, made_valid, made);
        if (made_valid) predicted_results.push_back(made);
      end
      if (out_mon.valid && out_mon.ready) begin
        got = {out_mon.kind, out_mon.sub_type, out_mon.payload_size,
               out_mon.rebased_timestamp, out_mon.raw_timestamp, out_mon.sub_stream_id,
               out_mon.data_out, out_mon.last_of_message};
        if (predicted_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: result with none expected: %s", $realtime, fmt_res(got));
        end else begin
          want = predicted_results.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("%0t: result mismatch", $realtime);
              $display("  expected %s", fmt_res(want));
              $display("  actual   %s", fmt_res(got));
            end
          end
        end
      end
    end
    pending = predicted_results.size();
  end

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps
module tb;
  import rad_pkg::*;

  logic clk = 1'b0;
  logic rst_n;
  int   fail_count;
  int   pending;
  int   cycle = 0;

  // Bytes of the aggregate being put together, and count of bytes sent through
  // send_agg.
  logic [7:0] agg_bytes[$];
  int         live_bytes = 0;
  bit         no_gaps = 1'b0;

  rad_in_if  in_ch();
  rad_out_if out_ch();

  rtmp_aggregate_deframer dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  rad_result_checker u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) cycle <= cycle + 1;

  function automatic int pick_gap(bit burst);
    int r;
    r = $urandom_range(0, 99);
    if (burst || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 25);
  endfunction

  function automatic logic [7:0] pick_type();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return TYPE_AUDIO;
    if (r < 90) return TYPE_VIDEO;
    return 8'($urandom);
  endfunction

  function automatic int pick_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return 0;
    if (r < 85) return $urandom_range(1, 12);
    if (r < 97) return $urandom_range(13, 40);
    return $urandom_range(41, 200);
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic start, input logic [23:0] len,
                           input logic [31:0] pts);
    int gap;
    gap = pick_gap(no_gaps);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid            <= 1'b1;
    in_ch.payload_byte     <= b;
    in_ch.aggregate_start  <= start;
    // Length and timestamp only matter on a start byte; elsewhere they are noise.
    in_ch.aggregate_length <= start ? len : 24'($urandom);
    in_ch.parent_timestamp <= start ? pts : $urandom;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic add_sub(input logic [7:0] mtype, input logic [23:0] size,
                         input logic [31:0] ts, input logic [23:0] sid);
    agg_bytes.push_back(mtype);
    agg_bytes.push_back(size[23:16]);
    agg_bytes.push_back(size[15:8]);
    agg_bytes.push_back(size[7:0]);
    agg_bytes.push_back(ts[23:16]);
    agg_bytes.push_back(ts[15:8]);
    agg_bytes.push_back(ts[7:0]);
    agg_bytes.push_back(ts[31:24]);
    agg_bytes.push_back(sid[23:16]);
    agg_bytes.push_back(sid[15:8]);
    agg_bytes.push_back(sid[7:0]);
    repeat (size) agg_bytes.push_back(8'($urandom));
    repeat (BACKPTR_LEN) agg_bytes.push_back(8'($urandom));
  endtask

  task automatic build_msgs(input int n);
    repeat (n) add_sub(pick_type(), 24'(pick_size()), $urandom, 24'($urandom));
  endtask

  task automatic send_agg(input logic [23:0] decl, input int nsend, input logic [31:0] pts);
    for (int i = 0; i < nsend; i++) send_byte(agg_bytes[i], i == 0, decl, pts);
    live_bytes += nsend;
    agg_bytes.delete();
  endtask

  // Receiver: random stalls, plus one long hold-off so the block backs up.
  initial begin
    bit hold_done;
    int gap;
    hold_done = 1'b0;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (!hold_done && cycle >= 300) begin
        out_ch.ready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_done = 1'b1;
      end
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 40)) @(posedge clk);
      gap = pick_gap(1'b0);
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  initial begin
    int r;
    int sz;
    int n;
    rst_n                  <= 1'b0;
    in_ch.valid            <= 1'b0;
    in_ch.payload_byte     <= '0;
    in_ch.aggregate_start  <= 1'b0;
    in_ch.aggregate_length <= '0;
    in_ch.parent_timestamp <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // A stray byte with no aggregate open, then an empty aggregate.
    send_byte(8'hFF, 1'b0, 24'd0, 32'd0);
    send_byte(8'h00, 1'b1, 24'd0, 32'hFFFF_FFFF);
    // Timestamp extremes so that the rebased value wraps.
    add_sub(TYPE_VIDEO, 24'd1, 32'hFFFF_FFFF, 24'hFF_FFFF);
    add_sub(TYPE_AUDIO, 24'd0, 32'h0000_0000, 24'h00_0000);
    sz = agg_bytes.size();
    send_agg(24'(sz), sz, 32'hFFFF_FFFF);
    // Aggregate that ends inside a sub-header.
    add_sub(TYPE_AUDIO, 24'd2, 32'h0000_1234, 24'h00_0001);
    send_agg(24'd5, 5, 32'd0);
    // Sub-header that announces far more data than the aggregate holds.
    add_sub(TYPE_VIDEO, 24'd0, $urandom, 24'($urandom));
    agg_bytes[1] = 8'hFF;
    agg_bytes[2] = 8'hFF;
    agg_bytes[3] = 8'hFF;
    send_agg(24'd15, 15, $urandom);
    // A dropped type, cut short by a new aggregate starting.
    add_sub(8'd18, 24'd3, $urandom, 24'h00_0005);
    add_sub(TYPE_AUDIO, 24'd2, $urandom, 24'h00_0006);
    sz = agg_bytes.size();
    send_agg(24'(sz), 13, $urandom);
    add_sub(TYPE_AUDIO, 24'd2, 32'h8000_0000, 24'h00_0007);
    sz = agg_bytes.size();
    send_agg(24'(sz), sz, $urandom);

    while (live_bytes < 650) begin
      no_gaps = ($urandom_range(0, 4) == 0);
      r = $urandom_range(0, 99);
      if (r < 68) begin
        build_msgs($urandom_range(1, 4));
        sz = agg_bytes.size();
        send_agg(24'(sz), sz, $urandom);
      end else if (r < 78) begin
        build_msgs($urandom_range(1, 3));
        n = $urandom_range(1, agg_bytes.size() - 1);
        send_agg(24'(n), n, $urandom);
      end else if (r < 86) begin
        // Declared longer than what is sent; the next start abandons it.
        build_msgs($urandom_range(2, 4));
        sz = agg_bytes.size();
        n  = $urandom_range(1, sz - 1);
        send_agg(24'(sz) | (24'($urandom) & 24'hFF_F000), n, $urandom);
      end else if (r < 93) begin
        repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'b0, 24'd0, 32'd0);
      end else if (r < 98) begin
        n = $urandom_range(11, 30);
        repeat (n) agg_bytes.push_back(8'($urandom));
        send_agg(24'(n), n, $urandom);
      end else begin
        send_byte(8'($urandom), 1'b1, 24'd0, $urandom);
      end
    end
    in_ch.valid <= 1'b0;

    // One more edge so that the checker has counted the last accepted item.
    @(posedge clk);
    wait (pending == 0);
    repeat (10) @(posedge clk);
    if (pending != 0) $display("%0d expected results never arrived", pending);
    if (fail_count == 0 && pending == 0) begin
      $display("** rtmp_aggregate_deframer: PASSED **");
    end else begin
      $display("** rtmp_aggregate_deframer: FAILED **");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout at %0t", $realtime);
    $display("** rtmp_aggregate_deframer: FAILED **");
    $finish;
  end

endmodule
